[design/icst_pkg.sv]
// Shared types, codes and constants of the interrupt controller with SysTick.
package icst_pkg;

	typedef enum logic [2:0] {
		OP_READ    = 3'd0,
		OP_WRITE   = 3'd1,
		OP_TICK    = 3'd2,
		OP_IRQ     = 3'd3,
		OP_NMI     = 3'd4,
		OP_HFAULT  = 3'd5,
		OP_PENDSV  = 3'd6
	} icst_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ADDR_ERR = 2'd1,
		ST_SIZE_ERR = 2'd2
	} icst_status_t;

	typedef enum logic [3:0] {
		RG_NONE,
		RG_ISER,
		RG_ICER,
		RG_ISPR,
		RG_ICPR,
		RG_PRIO,
		RG_CTRL,
		RG_LOAD,
		RG_VAL,
		RG_CALIB,
		RG_SHPR2,
		RG_SHPR3,
		RG_SHCSR
	} icst_region_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] addr;
		logic [31:0] wdata;
		logic        word_access;
		logic [5:0]  irq_line;
	} icst_req_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic [1:0]  status;
		logic        exc_valid;
		logic [5:0]  exc_number;
	} icst_rsp_t;

	localparam logic [11:0] ADDR_STK_CTRL  = 12'h010;
	localparam logic [11:0] ADDR_STK_LOAD  = 12'h014;
	localparam logic [11:0] ADDR_STK_VAL   = 12'h018;
	localparam logic [11:0] ADDR_STK_CALIB = 12'h01C;
	localparam logic [11:0] ADDR_SHPR2     = 12'hD1C;
	localparam logic [11:0] ADDR_SHPR3     = 12'hD20;
	localparam logic [11:0] ADDR_SHCSR     = 12'hD24;

	localparam logic [5:0] BANK_ISER = 6'h04;
	localparam logic [5:0] BANK_ICER = 6'h06;
	localparam logic [5:0] BANK_ISPR = 6'h08;
	localparam logic [5:0] BANK_ICPR = 6'h0A;
	localparam logic [1:0] PRIO_PAGE = 2'b01;

	localparam logic [23:0] MASK24     = 24'hFFFFFF;
	localparam logic [16:0] CTRL_WMASK = 17'h10007;
	localparam int          CTRL_ENABLE    = 0;
	localparam int          CTRL_TICKINT   = 1;
	localparam int          CTRL_COUNTFLAG = 16;
	localparam int          SHCSR_PENDSV   = 28;

	localparam logic [5:0] EXC_NMI      = 6'd2;
	localparam logic [5:0] EXC_HFAULT   = 6'd3;
	localparam logic [5:0] EXC_PENDSV   = 6'd14;
	localparam logic [5:0] EXC_SYSTICK  = 6'd15;
	localparam logic [5:0] EXC_IRQ_BASE = 6'd16;

endpackage

[design/icst_stream_if.sv]
// Valid/ready channel interface carrying one request or result payload.
interface icst_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/icst_decode.sv]
// Address decoder that maps a system control space offset to a register region.
module icst_decode #(
	parameter int NUM_PRIO_WORDS = 8
) (
	input  logic [11:0]           addr,
	output icst_pkg::icst_region_t region
);

	localparam logic [9:0] PRIO_LAST = 10'(4 * (NUM_PRIO_WORDS - 1));

	always_comb begin
		priority if (addr[11:6] == icst_pkg::BANK_ISER) begin
			region = icst_pkg::RG_ISER;
		end else if (addr[11:6] == icst_pkg::BANK_ICER) begin
			region = icst_pkg::RG_ICER;
		end else if (addr[11:6] == icst_pkg::BANK_ISPR) begin
			region = icst_pkg::RG_ISPR;
		end else if (addr[11:6] == icst_pkg::BANK_ICPR) begin
			region = icst_pkg::RG_ICPR;
		end else if (addr[11:10] == icst_pkg::PRIO_PAGE && addr[9:0] <= PRIO_LAST) begin
			region = icst_pkg::RG_PRIO;
		end else if (addr == icst_pkg::ADDR_STK_CTRL) begin
			region = icst_pkg::RG_CTRL;
		end else if (addr == icst_pkg::ADDR_STK_LOAD) begin
			region = icst_pkg::RG_LOAD;
		end else if (addr == icst_pkg::ADDR_STK_VAL) begin
			region = icst_pkg::RG_VAL;
		end else if (addr == icst_pkg::ADDR_STK_CALIB) begin
			region = icst_pkg::RG_CALIB;
		end else if (addr == icst_pkg::ADDR_SHPR2) begin
			region = icst_pkg::RG_SHPR2;
		end else if (addr == icst_pkg::ADDR_SHPR3) begin
			region = icst_pkg::RG_SHPR3;
		end else if (addr == icst_pkg::ADDR_SHCSR) begin
			region = icst_pkg::RG_SHCSR;
		end else begin
			region = icst_pkg::RG_NONE;
		end
	end

endmodule

[design/icst_regfile.sv]
// Controller and timer registers with request execution and IRQ delivery.
module icst_regfile #(
	parameter int NUM_IRQ        = 32,
	parameter int NUM_PRIO_WORDS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  icst_pkg::icst_req_t    req,
	input  icst_pkg::icst_region_t region,
	output icst_pkg::icst_rsp_t    rsp
);

	localparam logic [31:0] LINE_MASK = 32'((64'd1 << NUM_IRQ) - 64'd1);
	localparam int          PIDX_W    = (NUM_PRIO_WORDS > 1) ? $clog2(NUM_PRIO_WORDS) : 1;
	localparam logic [6:0]  IRQ_LIMIT = 7'(NUM_IRQ);

	logic [16:0] ctrl_q, ctrl_n;
	logic [23:0] reload_q, reload_n;
	logic [23:0] current_q, current_n;
	logic [31:0] enable_q, enable_n;
	logic [31:0] pending_q, pending_n;
	logic [31:0] prio_q [NUM_PRIO_WORDS];
	logic [31:0] shcsr_q, shcsr_n;
	logic [31:0] shpr2_q, shpr2_n;
	logic [31:0] shpr3_q, shpr3_n;

	logic [PIDX_W-1:0] prio_idx;
	logic              prio_we;
	logic [16:0]       ctrl_w;
	logic [31:0]       ready_lines;
	logic [31:0]       lowest;
	logic [4:0]        lowest_idx;
	logic              do_deliver;

	assign prio_idx = req.addr[PIDX_W+1:2];

	always_comb begin
		ready_lines = 32'd0;
		lowest      = 32'd0;
		lowest_idx  = 5'd0;
		do_deliver  = 1'b0;
		ctrl_w      = 17'd0;
		ctrl_n      = ctrl_q;
		reload_n    = reload_q;
		current_n   = current_q;
		enable_n    = enable_q;
		pending_n   = pending_q;
		shcsr_n     = shcsr_q;
		shpr2_n     = shpr2_q;
		shpr3_n     = shpr3_q;
		prio_we     = 1'b0;
		rsp         = '0;

		unique case (icst_pkg::icst_op_t'(req.op))
			icst_pkg::OP_READ: begin
				if (!req.word_access) begin
					rsp.status = icst_pkg::ST_SIZE_ERR;
				end else begin
					unique case (region)
						icst_pkg::RG_ISER:  rsp.rdata = enable_q;
						icst_pkg::RG_ISPR:  rsp.rdata = pending_q;
						icst_pkg::RG_PRIO:  rsp.rdata = prio_q[prio_idx];
						icst_pkg::RG_CTRL:  rsp.rdata = {15'd0, ctrl_q};
						icst_pkg::RG_LOAD:  rsp.rdata = {8'd0, reload_q};
						icst_pkg::RG_VAL:   rsp.rdata = {8'd0, current_q};
						icst_pkg::RG_SHPR2: rsp.rdata = shpr2_q;
						icst_pkg::RG_SHPR3: rsp.rdata = shpr3_q;
						icst_pkg::RG_SHCSR: rsp.rdata = shcsr_q;
						icst_pkg::RG_NONE:  rsp.status = icst_pkg::ST_ADDR_ERR;
						default:            rsp.rdata = 32'd0;
					endcase
				end
			end
			icst_pkg::OP_WRITE: begin
				if (!req.word_access) begin
					rsp.status = icst_pkg::ST_SIZE_ERR;
				end else begin
					do_deliver = (region != icst_pkg::RG_NONE);
					unique case (region)
						icst_pkg::RG_ISER: enable_n  = enable_q | (req.wdata & LINE_MASK);
						icst_pkg::RG_ICER: enable_n  = enable_q & ~req.wdata;
						icst_pkg::RG_ISPR: pending_n = pending_q | (req.wdata & LINE_MASK);
						icst_pkg::RG_ICPR: pending_n = pending_q & ~req.wdata;
						icst_pkg::RG_PRIO: prio_we   = 1'b1;
						icst_pkg::RG_CTRL: begin
							ctrl_w = (ctrl_q & (17'd1 << icst_pkg::CTRL_COUNTFLAG))
								| (req.wdata[16:0] & icst_pkg::CTRL_WMASK);
							if (!ctrl_w[icst_pkg::CTRL_ENABLE]) begin
								ctrl_w[icst_pkg::CTRL_COUNTFLAG] = 1'b0;
							end
							ctrl_n = ctrl_w;
						end
						icst_pkg::RG_LOAD:  reload_n  = req.wdata[23:0];
						icst_pkg::RG_VAL:   current_n = req.wdata[23:0];
						icst_pkg::RG_SHPR2: shpr2_n   = req.wdata;
						icst_pkg::RG_SHPR3: shpr3_n   = req.wdata;
						icst_pkg::RG_SHCSR: shcsr_n   = req.wdata;
						icst_pkg::RG_NONE:  rsp.status = icst_pkg::ST_ADDR_ERR;
						default:            ;
					endcase
				end
			end
			icst_pkg::OP_TICK: begin
				if (ctrl_q[icst_pkg::CTRL_ENABLE]) begin
					if (current_q == 24'd0) begin
						current_n = reload_q & icst_pkg::MASK24;
						ctrl_n[icst_pkg::CTRL_COUNTFLAG] = 1'b1;
						if (ctrl_q[icst_pkg::CTRL_TICKINT]) begin
							rsp.exc_valid  = 1'b1;
							rsp.exc_number = icst_pkg::EXC_SYSTICK;
						end
					end else begin
						current_n = current_q - 24'd1;
					end
				end
			end
			icst_pkg::OP_IRQ: begin
				if ({1'b0, req.irq_line} < IRQ_LIMIT) begin
					pending_n  = pending_q | (32'd1 << req.irq_line[4:0]);
					do_deliver = 1'b1;
				end
			end
			icst_pkg::OP_NMI: begin
				rsp.exc_valid  = 1'b1;
				rsp.exc_number = icst_pkg::EXC_NMI;
			end
			icst_pkg::OP_HFAULT: begin
				rsp.exc_valid  = 1'b1;
				rsp.exc_number = icst_pkg::EXC_HFAULT;
			end
			icst_pkg::OP_PENDSV: begin
				shcsr_n[icst_pkg::SHCSR_PENDSV] = 1'b1;
				rsp.exc_valid  = 1'b1;
				rsp.exc_number = icst_pkg::EXC_PENDSV;
			end
			default: ;
		endcase

		// The lowest pending and enabled line is taken after this request's update.
		if (do_deliver) begin
			ready_lines = enable_n & pending_n & LINE_MASK;
			lowest      = ready_lines & (~ready_lines + 32'd1);
			for (int i = 0; i < 32; i++) begin
				if (lowest[i]) begin
					lowest_idx = 5'(i);
				end
			end
			if (ready_lines != 32'd0) begin
				pending_n      = pending_n & ~lowest;
				rsp.exc_valid  = 1'b1;
				rsp.exc_number = icst_pkg::EXC_IRQ_BASE + {1'b0, lowest_idx};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '0;
			reload_q  <= '0;
			current_q <= '0;
			enable_q  <= '0;
			pending_q <= '0;
			shcsr_q   <= '0;
			shpr2_q   <= '0;
			shpr3_q   <= '0;
			for (int i = 0; i < NUM_PRIO_WORDS; i++) begin
				prio_q[i] <= '0;
			end
		end else if (fire) begin
			ctrl_q    <= ctrl_n;
			reload_q  <= reload_n;
			current_q <= current_n;
			enable_q  <= enable_n;
			pending_q <= pending_n;
			shcsr_q   <= shcsr_n;
			shpr2_q   <= shpr2_n;
			shpr3_q   <= shpr3_n;
			if (prio_we) begin
				prio_q[prio_idx] <= req.wdata;
			end
		end
	end

endmodule

[design/interrupt_controller_with_systick_unit.sv]
// Top level of the interrupt controller with SysTick timer.
//
// Requests arrive on the req channel: a bus read or write of the system
// control space, a timer tick, an IRQ trigger, or an NMI, HardFault or
// PendSV event. Every request yields exactly one result on the rsp channel
// with read data, a status code and an optional exception number.
// A request is captured in an input register, executed against the
// register state and written to the result register, and one request
// is accepted every cycle while results are taken.
// The register update and the IRQ priority encoder both sit between the
// input and result registers.
// When the receiver stalls, the result register holds its result and the
// input register holds one more request; then ready drops until rsp moves.
// Reset clears all controller and timer registers, priority words included,
// and empties both pipeline registers.
module interrupt_controller_with_systick_unit #(
	parameter int NUM_IRQ        = 32,
	parameter int NUM_PRIO_WORDS = 8
) (
	input logic clk,
	input logic arst_n,
	icst_stream_if.sink   req,
	icst_stream_if.source rsp
);

	logic                   valid_s1;
	icst_pkg::icst_req_t    req_s1;
	logic                   rsp_valid_q;
	icst_pkg::icst_rsp_t    rsp_q;
	logic                   advance;
	icst_pkg::icst_region_t region;
	icst_pkg::icst_rsp_t    result;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	icst_decode #(
		.NUM_PRIO_WORDS(NUM_PRIO_WORDS)
	) u_decode (
		.addr   (req_s1.addr),
		.region (region)
	);

	icst_regfile #(
		.NUM_IRQ        (NUM_IRQ),
		.NUM_PRIO_WORDS (NUM_PRIO_WORDS)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.region (region),
		.rsp    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	a_hold_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a request while the result stalled");

	a_no_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !valid_s1 || advance)
		else $error("request accepted into an occupied input register");

	a_advance_shows : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid)
		else $error("executed request produced no result");

	a_err_no_exc : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status != icst_pkg::ST_OK |-> !rsp.payload.exc_valid)
		else $error("exception signaled with a failed bus access");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the interrupt controller with SysTick timer.
`timescale 1ns / 100ps

module tb_top;

	localparam int          NUM_LINES  = 32;
	localparam int          TOTAL_REQS = 1850;
	localparam int          PHASE_LEN  = 620;
	localparam int          HOLD_LEN   = 200;
	localparam int          MAX_PRINTS = 100;
	localparam logic [2:0]  OP_UNUSED  = 3'd7;
	localparam logic [11:0] PRIO_BASE  = 12'h400;
	localparam logic [11:0] PRIO_LAST  = 12'h41C;
	localparam logic [11:0] ADDR_NONE  = 12'h000;
	localparam logic [11:0] ADDR_TOP   = 12'hFFF;

	logic clk;
	logic arst_n;

	icst_stream_if #(.payload_t(icst_pkg::icst_req_t)) req_if ();
	icst_stream_if #(.payload_t(icst_pkg::icst_rsp_t)) rsp_if ();

	interrupt_controller_with_systick_unit #(
		.NUM_IRQ        (NUM_LINES),
		.NUM_PRIO_WORDS (8)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [31:0] tick_ctrl;
	logic [23:0] tick_reload;
	logic [23:0] stk_val;
	logic [31:0] irq_enable;
	logic [31:0] irq_pending;
	logic [31:0] prio_word [8];
	logic [31:0] shpr2;
	logic [31:0] shpr3;
	logic [31:0] shcsr;

	icst_pkg::icst_req_t stim_q [$];
	icst_pkg::icst_rsp_t exp_rsp_q [$];
	int        total_reqs;
	int        accepted_cnt;
	int        checked_cnt;
	int        mismatch_cnt;
	int        exc_cnt;
	int        irq_deliv_cnt;
	int        systick_cnt;
	int        hold_left;
	bit        hold_done;

	function automatic void push_req(input logic [2:0] op, input logic [11:0] addr,
			input logic [31:0] wdata, input logic word, input logic [5:0] irq);
		icst_pkg::icst_req_t r;
		r.op          = op;
		r.addr        = addr;
		r.wdata       = wdata;
		r.word_access = word;
		r.irq_line    = irq;
		stim_q.push_back(r);
	endfunction

	function automatic bit deliver_lowest(output logic [5:0] num);
		logic [31:0] ready_lines;
		ready_lines = irq_enable & irq_pending;
		num = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			if (ready_lines[i]) begin
				irq_pending[i] = 1'b0;
				num = icst_pkg::EXC_IRQ_BASE + 6'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit scs_read(input logic [11:0] a, output logic [31:0] rd);
		rd = '0;
		scs_read = 1'b1;
		if (a[11:6] == icst_pkg::BANK_ISER) rd = irq_enable;
		else if (a[11:6] == icst_pkg::BANK_ISPR) rd = irq_pending;
		else if (a[11:6] == icst_pkg::BANK_ICER || a[11:6] == icst_pkg::BANK_ICPR) rd = '0;
		else if (a >= PRIO_BASE && a <= PRIO_LAST) rd = prio_word[a[4:2]];
		else begin
			case (a)
				icst_pkg::ADDR_STK_CTRL:  rd = tick_ctrl;
				icst_pkg::ADDR_STK_LOAD:  rd = {8'b0, tick_reload};
				icst_pkg::ADDR_STK_VAL:   rd = {8'b0, stk_val};
				icst_pkg::ADDR_STK_CALIB: rd = '0;
				icst_pkg::ADDR_SHPR2:     rd = shpr2;
				icst_pkg::ADDR_SHPR3:     rd = shpr3;
				icst_pkg::ADDR_SHCSR:     rd = shcsr;
				default:                  scs_read = 1'b0;
			endcase
		end
	endfunction

	function automatic bit scs_write(input logic [11:0] a, input logic [31:0] v);
		logic flag;
		scs_write = 1'b1;
		if (a[11:6] == icst_pkg::BANK_ISER) irq_enable = irq_enable | v;
		else if (a[11:6] == icst_pkg::BANK_ICER) irq_enable = irq_enable & ~v;
		else if (a[11:6] == icst_pkg::BANK_ISPR) irq_pending = irq_pending | v;
		else if (a[11:6] == icst_pkg::BANK_ICPR) irq_pending = irq_pending & ~v;
		else if (a >= PRIO_BASE && a <= PRIO_LAST) prio_word[a[4:2]] = v;
		else begin
			case (a)
				icst_pkg::ADDR_STK_CTRL: begin
					flag = tick_ctrl[icst_pkg::CTRL_COUNTFLAG];
					tick_ctrl = v & 32'(icst_pkg::CTRL_WMASK);
					tick_ctrl[icst_pkg::CTRL_COUNTFLAG] =
						tick_ctrl[icst_pkg::CTRL_COUNTFLAG] | flag;
					if (!tick_ctrl[icst_pkg::CTRL_ENABLE])
						tick_ctrl[icst_pkg::CTRL_COUNTFLAG] = 1'b0;
				end
				icst_pkg::ADDR_STK_LOAD:  tick_reload = v[23:0];
				icst_pkg::ADDR_STK_VAL:   stk_val = v[23:0];
				icst_pkg::ADDR_STK_CALIB: ;
				icst_pkg::ADDR_SHPR2:     shpr2 = v;
				icst_pkg::ADDR_SHPR3:     shpr3 = v;
				icst_pkg::ADDR_SHCSR:     shcsr = v;
				default:                  scs_write = 1'b0;
			endcase
		end
	endfunction

	function automatic icst_pkg::icst_rsp_t predict_rsp(input icst_pkg::icst_req_t r);
		icst_pkg::icst_rsp_t res;
		logic [31:0]         rd;
		logic [5:0]          num;
		res = '0;
		case (r.op)
			icst_pkg::OP_READ: begin
				if (!r.word_access) res.status = icst_pkg::ST_SIZE_ERR;
				else if (scs_read(r.addr, rd)) res.rdata = rd;
				else res.status = icst_pkg::ST_ADDR_ERR;
			end
			icst_pkg::OP_WRITE: begin
				if (!r.word_access) res.status = icst_pkg::ST_SIZE_ERR;
				else if (!scs_write(r.addr, r.wdata)) res.status = icst_pkg::ST_ADDR_ERR;
				else if (deliver_lowest(num)) begin
					res.exc_valid  = 1'b1;
					res.exc_number = num;
				end
			end
			icst_pkg::OP_TICK: begin
				if (tick_ctrl[icst_pkg::CTRL_ENABLE]) begin
					if (stk_val == '0) begin
						stk_val = tick_reload;
						tick_ctrl[icst_pkg::CTRL_COUNTFLAG] = 1'b1;
						if (tick_ctrl[icst_pkg::CTRL_TICKINT]) begin
							res.exc_valid  = 1'b1;
							res.exc_number = icst_pkg::EXC_SYSTICK;
						end
					end else begin
						stk_val = stk_val - 24'd1;
					end
				end
			end
			icst_pkg::OP_IRQ: begin
				if (r.irq_line < NUM_LINES) begin
					irq_pending[r.irq_line] = 1'b1;
					if (deliver_lowest(num)) begin
						res.exc_valid  = 1'b1;
						res.exc_number = num;
					end
				end
			end
			icst_pkg::OP_NMI: begin
				res.exc_valid  = 1'b1;
				res.exc_number = icst_pkg::EXC_NMI;
			end
			icst_pkg::OP_HFAULT: begin
				res.exc_valid  = 1'b1;
				res.exc_number = icst_pkg::EXC_HFAULT;
			end
			icst_pkg::OP_PENDSV: begin
				shcsr[icst_pkg::SHCSR_PENDSV] = 1'b1;
				res.exc_valid  = 1'b1;
				res.exc_number = icst_pkg::EXC_PENDSV;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_cnt < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int idle_phase();
		if (accepted_cnt < PHASE_LEN) return 0;
		if (accepted_cnt < 2 * PHASE_LEN) return 1;
		return 2;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Timeout waiting for the block to finish");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				exp_rsp_q.push_back(predict_rsp(req_if.payload));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (stim_q.size() > 0 &&
						!(idle_phase() == 0 && chance(8)) &&
						!(idle_phase() == 1 && chance(80))) begin
					req_if.valid   <= 1'b1;
					req_if.payload <= stim_q.pop_front();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// The receiver holds off once at the start of the last phase while requests keep coming.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && accepted_cnt >= 2 * PHASE_LEN) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		icst_pkg::icst_rsp_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (exp_rsp_q.size() == 0) begin
					report_mismatch("result arrived with no request outstanding");
				end else begin
					want = exp_rsp_q.pop_front();
					if (rsp_if.payload.rdata !== want.rdata)
						report_mismatch($sformatf("result %0d rdata got 0x%08h expected 0x%08h",
							checked_cnt, rsp_if.payload.rdata, want.rdata));
					if (rsp_if.payload.status !== want.status)
						report_mismatch($sformatf("result %0d status got %0d expected %0d",
							checked_cnt, rsp_if.payload.status, want.status));
					if (rsp_if.payload.exc_valid !== want.exc_valid)
						report_mismatch($sformatf("result %0d exc_valid got %0b expected %0b",
							checked_cnt, rsp_if.payload.exc_valid, want.exc_valid));
					if (rsp_if.payload.exc_number !== want.exc_number)
						report_mismatch($sformatf("result %0d exc_number got %0d expected %0d",
							checked_cnt, rsp_if.payload.exc_number, want.exc_number));
					if (want.exc_valid) begin
						exc_cnt <= exc_cnt + 1;
						if (want.exc_number >= icst_pkg::EXC_IRQ_BASE)
							irq_deliv_cnt <= irq_deliv_cnt + 1;
						if (want.exc_number == icst_pkg::EXC_SYSTICK)
							systick_cnt <= systick_cnt + 1;
					end
					checked_cnt <= checked_cnt + 1;
				end
			end
			rsp_if.ready <= (hold_left == 0) &&
				!(idle_phase() == 0 && chance(80)) &&
				!(idle_phase() == 1 && chance(8));
		end
	end

	initial begin
		icst_pkg::icst_req_t r;
		int                  pick;
		logic [11:0]         a;
		logic [31:0]         data;

		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		accepted_cnt   = 0;
		checked_cnt    = 0;
		mismatch_cnt   = 0;
		exc_cnt        = 0;
		irq_deliv_cnt  = 0;
		systick_cnt    = 0;
		hold_left      = 0;
		hold_done      = 1'b0;
		tick_ctrl      = '0;
		tick_reload    = '0;
		stk_val        = '0;
		irq_enable     = '0;
		irq_pending    = '0;
		shpr2          = '0;
		shpr3          = '0;
		shcsr          = '0;
		for (int i = 0; i < 8; i++) prio_word[i] = '0;

		// Directed opening: aliases, IRQ 0 and 31, ignored lines, timer wrap and error paths.
		push_req(icst_pkg::OP_READ,  {icst_pkg::BANK_ISER, 6'h00}, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, {icst_pkg::BANK_ISER, 6'h3C}, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, {icst_pkg::BANK_ISPR, 6'h00}, 32'h80000001, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,  {icst_pkg::BANK_ISPR, 6'h3F}, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_IRQ,   ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, {icst_pkg::BANK_ICPR, 6'h3F}, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_IRQ,   ADDR_NONE, 32'h0, 1'b1, 6'd31);
		push_req(icst_pkg::OP_IRQ,   ADDR_TOP, 32'hFFFFFFFF, 1'b1, 6'd63);
		push_req(icst_pkg::OP_IRQ,   ADDR_NONE, 32'h0, 1'b0, 6'd32);
		push_req(icst_pkg::OP_WRITE, {icst_pkg::BANK_ICER, 6'h00}, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_IRQ,   ADDR_NONE, 32'h0, 1'b1, 6'd5);
		push_req(icst_pkg::OP_WRITE, {icst_pkg::BANK_ISER, 6'h01}, 32'h00000020, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, icst_pkg::ADDR_STK_LOAD, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,  icst_pkg::ADDR_STK_LOAD, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, icst_pkg::ADDR_STK_CTRL, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_TICK,  ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_TICK,  ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, icst_pkg::ADDR_STK_VAL, 32'hFF000001, 1'b1, 6'd0);
		push_req(icst_pkg::OP_TICK,  ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_TICK,  ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,  icst_pkg::ADDR_STK_CTRL, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, icst_pkg::ADDR_STK_CTRL, 32'h00010000, 1'b1, 6'd0);
		push_req(icst_pkg::OP_TICK,  ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, icst_pkg::ADDR_STK_CALIB, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,  icst_pkg::ADDR_STK_CALIB, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, PRIO_LAST, 32'hFFFFFFFF, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, PRIO_BASE + 12'd1, 32'h12345678, 1'b1, 6'd0);
		push_req(icst_pkg::OP_WRITE, PRIO_LAST + 12'd2, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,  ADDR_TOP, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,  icst_pkg::ADDR_SHCSR, 32'h0, 1'b0, 6'd0);
		push_req(icst_pkg::OP_WRITE, icst_pkg::ADDR_SHPR2, 32'hFFFFFFFF, 1'b0, 6'd0);
		push_req(icst_pkg::OP_NMI,    ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_HFAULT, ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_PENDSV, ADDR_NONE, 32'h0, 1'b1, 6'd0);
		push_req(icst_pkg::OP_READ,   icst_pkg::ADDR_SHCSR, 32'h0, 1'b1, 6'd0);
		push_req(OP_UNUSED,           ADDR_TOP, 32'hFFFFFFFF, 1'b1, 6'd63);

		for (int n = stim_q.size(); n < TOTAL_REQS; n++) begin
			pick = $urandom_range(0, 99);
			r.op = pick < 20 ? icst_pkg::OP_READ : pick < 50 ? icst_pkg::OP_WRITE :
				pick < 75 ? icst_pkg::OP_TICK : pick < 90 ? icst_pkg::OP_IRQ :
				pick < 93 ? icst_pkg::OP_NMI : pick < 96 ? icst_pkg::OP_HFAULT :
				pick < 98 ? icst_pkg::OP_PENDSV : OP_UNUSED;
			case ($urandom_range(0, 11))
				0:       a = icst_pkg::ADDR_STK_CTRL;
				1:       a = icst_pkg::ADDR_STK_LOAD;
				2:       a = icst_pkg::ADDR_STK_VAL;
				3:       a = icst_pkg::ADDR_STK_CALIB;
				4:       a = {icst_pkg::BANK_ISER, 6'($urandom_range(0, 63))};
				5:       a = {icst_pkg::BANK_ICER, 6'($urandom_range(0, 63))};
				6:       a = {icst_pkg::BANK_ISPR, 6'($urandom_range(0, 63))};
				7:       a = {icst_pkg::BANK_ICPR, 6'($urandom_range(0, 63))};
				8:       a = PRIO_BASE + 12'($urandom_range(0, 31));
				9:       a = icst_pkg::ADDR_SHPR2;
				10:      a = $urandom_range(0, 1) ? icst_pkg::ADDR_SHPR3 : icst_pkg::ADDR_SHCSR;
				default: a = 12'($urandom);
			endcase
			data = $urandom;
			if (a == icst_pkg::ADDR_STK_LOAD || a == icst_pkg::ADDR_STK_VAL) begin
				if ($urandom_range(0, 9) != 0) data = $urandom_range(0, 6);
			end else if (a == icst_pkg::ADDR_STK_CTRL) begin
				if ($urandom_range(0, 4) != 0) data[icst_pkg::CTRL_ENABLE] = 1'b1;
			end else if (a[11:6] == icst_pkg::BANK_ISER || a[11:6] == icst_pkg::BANK_ISPR) begin
				data = data & $urandom & $urandom;
			end else if (a[11:6] == icst_pkg::BANK_ICER || a[11:6] == icst_pkg::BANK_ICPR) begin
				data = data & $urandom;
			end
			r.addr        = a;
			r.wdata       = data;
			r.word_access = $urandom_range(0, 15) != 0;
			r.irq_line    = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 31)) :
				6'($urandom_range(32, 63));
			stim_q.push_back(r);
		end
		total_reqs = stim_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted_cnt == total_reqs);
		wait (checked_cnt == accepted_cnt);
		repeat (10) @(posedge clk);

		if (exp_rsp_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", exp_rsp_q.size()));
		$display("Checked %0d results for %0d requests under three stall patterns.",
			checked_cnt, total_reqs);
		$display("Exceptions seen: %0d in total, %0d IRQ, %0d SysTick; %0d mismatches.",
			exc_cnt, irq_deliv_cnt, systick_cnt, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
design/icst_pkg.sv
design/icst_stream_if.sv
design/icst_decode.sv
design/icst_regfile.sv
design/interrupt_controller_with_systick_unit.sv
tb/tb_top.sv
